// ===== rtl/core/pol_pkg.sv =====
// ----------------------------------------------------------------------------
// pol_pkg
// Shared types and constants for the patch obstacle labeler.
// ----------------------------------------------------------------------------
`default_nettype none

package pol_pkg;

	// Register file layout
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PATCH_SIDE      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RATIO_THRESHOLD = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_CHECK_EN  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_LIMIT     = 3'd5;

	// Field widths
	localparam int DIM_W   = 13;
	localparam int SIDE_W  = 7;
	localparam int SQ_W    = 2 * SIDE_W;
	localparam int THR_W   = 16;
	localparam int PROD_W  = THR_W + SQ_W;
	localparam int DEPTH_W = 16;
	localparam int OV_W    = 8;
	localparam int COORD_W = 12;
	localparam int SUM_W   = 20;

	localparam logic [SUM_W-1:0]   SUM_MAX    = '1;
	localparam logic [DEPTH_W-1:0] DEPTH_NONE = '1;

	// Reset values of the registers
	localparam logic [DIM_W-1:0]   RST_IMAGE_WIDTH  = 13'd640;
	localparam logic [DIM_W-1:0]   RST_IMAGE_HEIGHT = 13'd480;
	localparam logic [SIDE_W-1:0]  RST_PATCH_SIDE   = 7'd16;
	localparam logic [THR_W-1:0]   RST_RATIO_THR    = 16'd128;
	localparam logic [DEPTH_W-1:0] RST_RANGE_LIMIT  = 16'hFFFF;

	// Live configuration, with the threshold product precomputed
	typedef struct packed {
		logic [DIM_W-1:0]   image_width;
		logic [DIM_W-1:0]   image_height;
		logic [SIDE_W-1:0]  side;
		logic [PROD_W-1:0]  thr_prod;
		logic               range_en;
		logic [DEPTH_W-1:0] range_limit;
	} cfg_t;

	// Finished patch totals handed to the labeling stage
	typedef struct packed {
		logic [SUM_W-1:0]   sum;
		logic [DEPTH_W-1:0] min_obs;
		logic [DEPTH_W-1:0] min_any;
		logic [COORD_W-1:0] cx;
		logic [COORD_W-1:0] cy;
	} totals_t;

endpackage

`default_nettype wire

// ===== rtl/core/patch_obstacle_labeler.sv =====
// ----------------------------------------------------------------------------
// patch_obstacle_labeler
// Labels a square image patch from a stream of its pixels, one pixel per
// transaction on the input channel (valid/ready). The pixel flagged last
// closes the patch and produces one transaction on the output channel
// carrying the obstacle label, the nearest obstacle depth and a valid flag.
// Throughput is one pixel per cycle. A result passes through the input
// register, holding stage and output register before it is offered.
// Pixels that do not close a patch always drain into the accumulators;
// a closing pixel waits only while both the holding stage and the output
// register are full, so the input stalls only when the receiver holds off
// two pending results. Configuration writes on the cfg port take effect
// once the threshold product register has caught up. Reset clears the
// pipeline and accumulators and loads the register defaults; no clearing
// pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module patch_obstacle_labeler import pol_pkg::*; #(
	parameter int MAX_PATCH_SIDE = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [OV_W-1:0]       obstacle_value,
	input  wire logic [DEPTH_W-1:0]    pixel_distance,
	input  wire logic [COORD_W-1:0]    center_x,
	input  wire logic [COORD_W-1:0]    center_y,
	input  wire logic                  last_pixel,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       obstacle_label,
	output logic [DEPTH_W-1:0]         obstacle_distance,
	output logic                       patch_valid
);

	cfg_t    cfg;
	totals_t tot;
	logic    tot_valid;
	logic    tot_ready;

	pol_cfg #(
		.MAX_PATCH_SIDE(MAX_PATCH_SIDE)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pol_accum u_accum (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.obstacle_value (obstacle_value),
		.pixel_distance (pixel_distance),
		.center_x       (center_x),
		.center_y       (center_y),
		.last_pixel     (last_pixel),
		.tot_valid      (tot_valid),
		.tot_ready      (tot_ready),
		.tot            (tot)
	);

	pol_label u_label (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (cfg),
		.tot_valid         (tot_valid),
		.tot_ready         (tot_ready),
		.tot               (tot),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.obstacle_label    (obstacle_label),
		.obstacle_distance (obstacle_distance),
		.patch_valid       (patch_valid)
	);

endmodule

`default_nettype wire

// ===== rtl/core/pol_cfg.sv =====
// ----------------------------------------------------------------------------
// pol_cfg
// Configuration registers; keeps side squared and the obstacle threshold
// product in registers so the labeling stage needs only a compare.
// ----------------------------------------------------------------------------
`default_nettype none

module pol_cfg import pol_pkg::*; #(
	parameter int MAX_PATCH_SIDE = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                       cfg
);

	localparam int SIDE_CAP = (MAX_PATCH_SIDE > 127) ? 127 : MAX_PATCH_SIDE;
	localparam logic [SIDE_W-1:0] SIDE_CAP_W = SIDE_CAP[SIDE_W-1:0];

	logic [DIM_W-1:0]   image_width_q;
	logic [DIM_W-1:0]   image_height_q;
	logic [SIDE_W-1:0]  side_q;
	logic [THR_W-1:0]   ratio_thr_q;
	logic               range_en_q;
	logic [DEPTH_W-1:0] range_limit_q;
	logic [SQ_W-1:0]    side_sq_q;
	logic [PROD_W-1:0]  thr_prod_q;
	logic [SIDE_W-1:0]  side_wr;

	// Clamp the written side to the supported maximum
	always_comb begin
		side_wr = cfg_data[SIDE_W-1:0];
		if (side_wr > SIDE_CAP_W) begin
			side_wr = SIDE_CAP_W;
		end
	end

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= RST_IMAGE_WIDTH;
			image_height_q <= RST_IMAGE_HEIGHT;
			side_q         <= RST_PATCH_SIDE;
			ratio_thr_q    <= RST_RATIO_THR;
			range_en_q     <= 1'b0;
			range_limit_q  <= RST_RANGE_LIMIT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:     image_width_q  <= cfg_data[DIM_W-1:0];
				REG_IMAGE_HEIGHT:    image_height_q <= cfg_data[DIM_W-1:0];
				REG_PATCH_SIDE:      side_q         <= side_wr;
				REG_RATIO_THRESHOLD: ratio_thr_q    <= cfg_data[THR_W-1:0];
				REG_RANGE_CHECK_EN:  range_en_q     <= cfg_data[0];
				REG_RANGE_LIMIT:     range_limit_q  <= cfg_data[DEPTH_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Derived products, one multiply per register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_sq_q  <= SQ_W'(RST_PATCH_SIDE) * SQ_W'(RST_PATCH_SIDE);
			thr_prod_q <= PROD_W'(RST_RATIO_THR) * PROD_W'(SQ_W'(RST_PATCH_SIDE)
				* SQ_W'(RST_PATCH_SIDE));
		end else begin
			side_sq_q  <= SQ_W'(side_q) * SQ_W'(side_q);
			thr_prod_q <= PROD_W'(ratio_thr_q) * PROD_W'(side_sq_q);
		end
	end

	assign cfg.image_width  = image_width_q;
	assign cfg.image_height = image_height_q;
	assign cfg.side         = side_q;
	assign cfg.thr_prod     = thr_prod_q;
	assign cfg.range_en     = range_en_q;
	assign cfg.range_limit  = range_limit_q;

endmodule

`default_nettype wire

// ===== rtl/core/pol_accum.sv =====
// ----------------------------------------------------------------------------
// pol_accum
// Input register and patch accumulators: obstacle sum and the two minimum
// depths. On the last pixel the totals move to a holding stage and the
// accumulators clear for the next patch.
// ----------------------------------------------------------------------------
`default_nettype none

module pol_accum import pol_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [OV_W-1:0]    obstacle_value,
	input  wire logic [DEPTH_W-1:0] pixel_distance,
	input  wire logic [COORD_W-1:0] center_x,
	input  wire logic [COORD_W-1:0] center_y,
	input  wire logic               last_pixel,
	output logic                    tot_valid,
	input  wire logic               tot_ready,
	output totals_t                 tot
);

	logic               v_s1;
	logic [OV_W-1:0]    ov_s1;
	logic [DEPTH_W-1:0] dist_s1;
	logic [COORD_W-1:0] cx_s1;
	logic [COORD_W-1:0] cy_s1;
	logic               last_s1;

	logic [SUM_W-1:0]   sum_q;
	logic [DEPTH_W-1:0] min_obs_q;
	logic [DEPTH_W-1:0] min_any_q;

	logic               v_s2;
	totals_t            tot_s2;

	logic               en2;
	logic               adv1;
	logic               take;
	logic [SUM_W:0]     sum_wide;
	logic [SUM_W-1:0]   sum_nx;
	logic [DEPTH_W-1:0] min_obs_nx;
	logic [DEPTH_W-1:0] min_any_nx;

	// Flow control: non-last pixels always drain into the accumulators
	assign en2      = !v_s2 || tot_ready;
	assign adv1     = !v_s1 || !last_s1 || en2;
	assign take     = v_s1 && adv1;
	assign in_ready = adv1;

	// Accumulator update including the current pixel
	always_comb begin
		sum_wide   = {1'b0, sum_q} + (SUM_W+1)'(ov_s1);
		sum_nx     = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
		min_obs_nx = min_obs_q;
		if (ov_s1 != '0 && dist_s1 < min_obs_q) begin
			min_obs_nx = dist_s1;
		end
		min_any_nx = (dist_s1 < min_any_q) ? dist_s1 : min_any_q;
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && adv1) begin
			ov_s1   <= obstacle_value;
			dist_s1 <= pixel_distance;
			cx_s1   <= center_x;
			cy_s1   <= center_y;
			last_s1 <= last_pixel;
		end
	end

	// Accumulators: update per pixel, clear after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q     <= '0;
			min_obs_q <= DEPTH_NONE;
			min_any_q <= DEPTH_NONE;
		end else if (take) begin
			if (last_s1) begin
				sum_q     <= '0;
				min_obs_q <= DEPTH_NONE;
				min_any_q <= DEPTH_NONE;
			end else begin
				sum_q     <= sum_nx;
				min_obs_q <= min_obs_nx;
				min_any_q <= min_any_nx;
			end
		end
	end

	// Holding stage for finished totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take && last_s1) begin
			tot_s2.sum     <= sum_nx;
			tot_s2.min_obs <= min_obs_nx;
			tot_s2.min_any <= min_any_nx;
			tot_s2.cx      <= cx_s1;
			tot_s2.cy      <= cy_s1;
		end
	end

	assign tot_valid = v_s2;
	assign tot       = tot_s2;

endmodule

`default_nettype wire

// ===== rtl/core/pol_label.sv =====
// ----------------------------------------------------------------------------
// pol_label
// Labeling stage: bounds check, obstacle ratio compare and range check,
// into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pol_label import pol_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  cfg_t                     cfg,
	input  wire logic                tot_valid,
	output logic                     tot_ready,
	input  totals_t                  tot,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic                     obstacle_label,
	output logic [DEPTH_W-1:0]       obstacle_distance,
	output logic                     patch_valid
);

	localparam int DBL_W = DIM_W + 1;

	logic               out_valid_q;
	logic               label_q;
	logic [DEPTH_W-1:0] dist_q;
	logic               pvalid_q;

	logic               en3;
	logic [DBL_W-1:0]   dx;
	logic [DBL_W-1:0]   dy;
	logic [DBL_W-1:0]   side_w;
	logic               in_bounds;
	logic               ratio_hit;
	logic               range_bad;
	logic               label_nx;
	logic [DEPTH_W-1:0] dist_nx;
	logic               pvalid_nx;

	assign en3       = !out_valid_q || out_ready;
	assign tot_ready = en3;

	// Compare doubled centre coordinates against the patch side
	always_comb begin
		dx     = DBL_W'({tot.cx, 1'b0});
		dy     = DBL_W'({tot.cy, 1'b0});
		side_w = DBL_W'(cfg.side);
		in_bounds = (dx + side_w <= {cfg.image_width, 1'b0}) && (dx >= side_w) &&
			(dy + side_w <= {cfg.image_height, 1'b0}) && (dy >= side_w);
		ratio_hit = {2'b00, tot.sum, 8'h00} > cfg.thr_prod;
		range_bad = cfg.range_en && ((tot.min_any > cfg.range_limit) ||
			(ratio_hit && tot.min_obs > cfg.range_limit));
		if (in_bounds) begin
			label_nx  = ratio_hit;
			dist_nx   = tot.min_obs;
			pvalid_nx = !range_bad;
		end else begin
			label_nx  = 1'b1;
			dist_nx   = DEPTH_NONE;
			pvalid_nx = 1'b0;
		end
	end

	// Output register, hold while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en3) begin
			out_valid_q <= tot_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tot_valid && en3) begin
			label_q  <= label_nx;
			dist_q   <= dist_nx;
			pvalid_q <= pvalid_nx;
		end
	end

	assign out_valid         = out_valid_q;
	assign obstacle_label    = label_q;
	assign obstacle_distance = dist_q;
	assign patch_valid       = pvalid_q;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Streams pixel patches into patch_obstacle_labeler and checks every label
// transaction against a cycle-free model of the labeling rules. Directed
// patches cover field extremes, image bounds, range rejection, side zero,
// oversized sides and long patches at the ratio threshold. A long receiver
// hold-off fills the pipeline. Random phases with varied register settings
// and random idling follow.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench import pol_pkg::*; ();

	localparam int MAX_SIDE    = 64;
	localparam int STALL_LIMIT = 2000;
	localparam int MAX_REPORTS = 10;

	// Indexes past the register list; writes there must have no effect
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

	typedef struct packed {
		logic               label;
		logic [DEPTH_W-1:0] distance;
		logic               valid;
	} patch_label_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [OV_W-1:0]       obstacle_value;
	logic [DEPTH_W-1:0]    pixel_distance;
	logic [COORD_W-1:0]    center_x;
	logic [COORD_W-1:0]    center_y;
	logic                  last_pixel;
	logic                  out_valid;
	logic                  out_ready;
	logic                  obstacle_label;
	logic [DEPTH_W-1:0]    obstacle_distance;
	logic                  patch_valid;

	// Model copy of the registers
	logic [DIM_W-1:0]   cfg_width;
	logic [DIM_W-1:0]   cfg_height;
	logic [SIDE_W-1:0]  cfg_side;
	logic [THR_W-1:0]   cfg_thr;
	logic               cfg_range_en;
	logic [DEPTH_W-1:0] cfg_range_limit;

	// Model copy of the patch accumulators
	logic [SUM_W-1:0]   acc_sum;
	logic [DEPTH_W-1:0] acc_min_obs;
	logic [DEPTH_W-1:0] acc_min_any;

	patch_label_t expected_labels[$];
	int           mismatch_count = 0;
	int           quiet_cycles = 0;
	int           sender_max_gap = 10;
	int           receiver_max_stall = 10;
	int           hold_request = 0;

	patch_obstacle_labeler DUT (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.obstacle_value    (obstacle_value),
		.pixel_distance    (pixel_distance),
		.center_x          (center_x),
		.center_y          (center_y),
		.last_pixel        (last_pixel),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.obstacle_label    (obstacle_label),
		.obstacle_distance (obstacle_distance),
		.patch_valid       (patch_valid)
	);

	always #10 clk = ~clk;

	// ------------------------------------------------------------------
	// Labeling model
	// ------------------------------------------------------------------
	function automatic void clear_patch();
		acc_sum = '0;
		acc_min_obs = DEPTH_NONE;
		acc_min_any = DEPTH_NONE;
	endfunction

	function automatic void reset_labeler_model();
		cfg_width = RST_IMAGE_WIDTH;
		cfg_height = RST_IMAGE_HEIGHT;
		cfg_side = RST_PATCH_SIDE;
		cfg_thr = RST_RATIO_THR;
		cfg_range_en = 1'b0;
		cfg_range_limit = RST_RANGE_LIMIT;
		clear_patch();
	endfunction

	function automatic void update_register(logic [CFG_IDX_W-1:0] idx,
			logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_IMAGE_WIDTH: cfg_width = data[DIM_W-1:0];
			REG_IMAGE_HEIGHT: cfg_height = data[DIM_W-1:0];
			REG_PATCH_SIDE: begin
				// saturate oversized sides
				if (data[SIDE_W-1:0] > MAX_SIDE)
					cfg_side = SIDE_W'(MAX_SIDE);
				else
					cfg_side = data[SIDE_W-1:0];
			end
			REG_RATIO_THRESHOLD: cfg_thr = data[THR_W-1:0];
			REG_RANGE_CHECK_EN: cfg_range_en = data[0];
			REG_RANGE_LIMIT: cfg_range_limit = data[DEPTH_W-1:0];
			default: ;
		endcase
	endfunction

	// Fold one pixel into the patch; on the closing pixel queue its label
	function automatic void accumulate_pixel(logic [OV_W-1:0] ov, logic [DEPTH_W-1:0] depth,
			logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy, logic last);
		logic [SUM_W:0] wide;
		patch_label_t   r;
		int             s;
		int             dx;
		int             dy;
		logic           in_img;
		longint         lhs;
		longint         rhs;
		wide = acc_sum + ov;
		acc_sum = (wide > SUM_MAX) ? SUM_MAX : wide[SUM_W-1:0];
		if (ov != 0 && depth < acc_min_obs)
			acc_min_obs = depth;
		if (depth < acc_min_any)
			acc_min_any = depth;
		if (!last)
			return;
		// compare doubled centre against the patch side
		s = int'(cfg_side);
		dx = 2 * int'(cx);
		dy = 2 * int'(cy);
		in_img = !(dx + s > 2 * int'(cfg_width) || dx < s ||
			dy + s > 2 * int'(cfg_height) || dy < s);
		if (!in_img) begin
			r.label = 1'b1;
			r.distance = DEPTH_NONE;
			r.valid = 1'b0;
		end else begin
			lhs = acc_sum;
			lhs = lhs * 256;
			rhs = cfg_thr;
			rhs = rhs * s * s;
			r.label = lhs > rhs;
			r.distance = acc_min_obs;
			r.valid = 1'b1;
			if (cfg_range_en && (acc_min_any > cfg_range_limit ||
					(r.label && acc_min_obs > cfg_range_limit)))
				r.valid = 1'b0;
		end
		expected_labels = {expected_labels, r};
		clear_patch();
	endfunction

	// ------------------------------------------------------------------
	// Result side: random stalls, optional long hold-off, compare
	// ------------------------------------------------------------------
	task automatic compare_label();
		patch_label_t exp_r;
		if (expected_labels.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= MAX_REPORTS)
				$display("%0t: unexpected label transaction label=%0d dist=%h valid=%0d",
					$time, obstacle_label, obstacle_distance, patch_valid);
		end else begin
			exp_r = expected_labels.pop_front();
			if (obstacle_label !== exp_r.label || obstacle_distance !== exp_r.distance ||
					patch_valid !== exp_r.valid) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("%0t: mismatch exp %0d/%h/%0d got %0d/%h/%0d",
						$time, exp_r.label, exp_r.distance, exp_r.valid,
						obstacle_label, obstacle_distance, patch_valid);
			end
		end
	endtask

	initial begin : label_sink
		int stall;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = $urandom_range(0, receiver_max_stall);
			if (hold_request > 0) begin
				stall = hold_request;
				hold_request = 0;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			compare_label();
		end
	end

	// End the run when no transaction moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Pixel side
	// ------------------------------------------------------------------
	task automatic send_pixel(logic [OV_W-1:0] ov, logic [DEPTH_W-1:0] depth,
			logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy, logic last);
		int gap;
		gap = $urandom_range(0, sender_max_gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		obstacle_value <= ov;
		pixel_distance <= depth;
		center_x <= cx;
		center_y <= cy;
		last_pixel <= last;
		do @(posedge clk); while (!in_ready);
		accumulate_pixel(ov, depth, cx, cy, last);
	endtask

	// Drop valid, wait for all labels, then let the pipeline settle
	task automatic drain_labels();
		in_valid <= 1'b0;
		while (expected_labels.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		update_register(idx, data);
	endtask

	task automatic set_registers(logic [15:0] w, logic [15:0] h, logic [15:0] side,
			logic [15:0] thr, logic [15:0] en, logic [15:0] max_r);
		drain_labels();
		write_register(REG_IMAGE_WIDTH, w);
		write_register(REG_IMAGE_HEIGHT, h);
		write_register(REG_PATCH_SIDE, side);
		write_register(REG_RATIO_THRESHOLD, thr);
		write_register(REG_RANGE_CHECK_EN, en);
		write_register(REG_RANGE_LIMIT, max_r);
		write_register(REG_SPARE_A, CFG_DATA_W'($urandom));
		write_register(REG_SPARE_B, CFG_DATA_W'($urandom));
		cfg_we <= 1'b0;
		repeat (4) @(posedge clk);
	endtask

	// Centre coordinate: mostly inside the image, some at the edges, some anywhere
	function automatic logic [COORD_W-1:0] pick_center(int dim, int side);
		int lo;
		int hi;
		int c;
		int mode;
		lo = (side + 1) / 2;
		hi = (2 * dim - side) / 2;
		mode = $urandom_range(0, 9);
		if (mode < 7 && lo <= hi)
			c = $urandom_range(hi, lo);
		else if (mode < 9)
			c = $urandom_range(0, 1) ? lo - 1 : hi + 1;
		else
			c = $urandom_range(0, 4095);
		if (c < 0)
			c = 0;
		if (c > 4095)
			c = 4095;
		return c[COORD_W-1:0];
	endfunction

	task automatic send_random_patch(output int count);
		int             len;
		int             dens;
		int             side;
		logic [15:0]    floor_d;
		logic [OV_W-1:0] ov;
		logic           last;
		side = int'(cfg_side);
		if (side >= 1 && side <= 6 && $urandom_range(0, 3) != 0)
			len = side * side;
		else
			len = $urandom_range(1, 24);
		dens = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 100);
		floor_d = ($urandom_range(0, 3) == 0) ? 16'h0 : 16'($urandom_range(0, 65535));
		for (int i = 0; i < len; i++) begin
			last = (i == len - 1);
			if ($urandom_range(1, 100) <= dens)
				ov = $urandom_range(0, 3) == 0 ? 8'hFF : 8'($urandom_range(1, 255));
			else
				ov = '0;
			if (last)
				send_pixel(ov, 16'($urandom_range(floor_d, 65535)),
					pick_center(int'(cfg_width), side),
					pick_center(int'(cfg_height), side), 1'b1);
			else
				send_pixel(ov, 16'($urandom_range(floor_d, 65535)),
					12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)), 1'b0);
		end
		count = len;
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	task automatic test_reset_defaults();
		// empty patch, depth extremes
		send_pixel(8'h00, 16'h0000, 12'd100, 12'd100, 1'b0);
		send_pixel(8'h00, 16'hFFFF, 12'd320, 12'd240, 1'b1);
		// obstacle patch
		send_pixel(8'hFF, 16'hFFFF, 12'd0, 12'd0, 1'b0);
		send_pixel(8'hFF, 16'h0000, 12'd4095, 12'd4095, 1'b0);
		send_pixel(8'h01, 16'h1234, 12'd320, 12'd240, 1'b1);
		// bounds edges for a 640x480 image and side 16
		send_pixel(8'hFF, 16'h0200, 12'd8, 12'd8, 1'b1);
		send_pixel(8'hFF, 16'h0200, 12'd632, 12'd472, 1'b1);
		send_pixel(8'hFF, 16'h0200, 12'd7, 12'd240, 1'b1);
		send_pixel(8'hFF, 16'h0200, 12'd633, 12'd240, 1'b1);
		send_pixel(8'hFF, 16'h0200, 12'd320, 12'd7, 1'b1);
		send_pixel(8'hFF, 16'h0200, 12'd320, 12'd473, 1'b1);
		send_pixel(8'hFF, 16'h0200, 12'd0, 12'd0, 1'b1);
		send_pixel(8'hFF, 16'h0200, 12'd4095, 12'd4095, 1'b1);
	endtask

	task automatic test_range_check();
		set_registers(16'd640, 16'd480, 16'd4, 16'd128, 16'd1, 16'h0100);
		// nearest point beyond range
		send_pixel(8'h00, 16'h0200, 12'd50, 12'd50, 1'b0);
		send_pixel(8'h00, 16'h0300, 12'd50, 12'd50, 1'b1);
		// nearest obstacle beyond range
		send_pixel(8'h00, 16'h0080, 12'd50, 12'd50, 1'b0);
		send_pixel(8'hFF, 16'h0200, 12'd50, 12'd50, 1'b1);
		// obstacle exactly at range
		send_pixel(8'hFF, 16'h0100, 12'd50, 12'd50, 1'b1);
		set_registers(16'd640, 16'd480, 16'd4, 16'd128, 16'd1, 16'h0000);
		send_pixel(8'h00, 16'h0000, 12'd50, 12'd50, 1'b1);
	endtask

	task automatic test_side_extremes();
		// side zero, widest image, zero height, upper bits dropped
		set_registers(16'hFFFF, 16'd0, 16'd0, 16'd0, 16'hFFFE, 16'hFFFF);
		send_pixel(8'h01, 16'h0005, 12'd4095, 12'd0, 1'b1);
		send_pixel(8'h00, 16'h0005, 12'd0, 12'd0, 1'b1);
		send_pixel(8'h00, 16'h0005, 12'd0, 12'd1, 1'b1);
		// oversized side saturates
		set_registers(16'd4096, 16'd4096, 16'hFFFF, 16'hFFFF, 16'd1, 16'hFFFF);
		send_pixel(8'hFF, 16'h0000, 12'd32, 12'd32, 1'b1);
		send_pixel(8'hFF, 16'h0000, 12'd31, 12'd32, 1'b1);
	endtask

	// A 100-pixel full patch sits right between thresholds 1593 and 1594
	task automatic test_large_sum();
		set_registers(16'd4096, 16'd4096, 16'd64, 16'd1593, 16'd0, 16'hFFFF);
		sender_max_gap = 0;
		receiver_max_stall = 0;
		for (int i = 0; i < 100; i++)
			send_pixel(8'hFF, 16'(i * 7), 12'd2048, 12'd2048, i == 99);
		set_registers(16'd4096, 16'd4096, 16'd64, 16'd1594, 16'd0, 16'hFFFF);
		for (int i = 0; i < 100; i++)
			send_pixel(8'hFF, 16'(65535 - i), 12'd2048, 12'd2048, i == 99);
		sender_max_gap = 10;
		receiver_max_stall = 10;
	endtask

	// Hold the receiver off while closing pixels keep coming
	task automatic test_backpressure();
		set_registers(16'd64, 16'd64, 16'd2, 16'($urandom_range(0, 65535)), 16'd0, 16'hFFFF);
		sender_max_gap = 0;
		hold_request = 150;
		for (int i = 0; i < 40; i++)
			send_pixel(8'($urandom_range(0, 255)), 16'($urandom),
				pick_center(64, 2), pick_center(64, 2), 1'b1);
		sender_max_gap = 10;
	endtask

	task automatic test_random_traffic();
		logic [15:0] side_d;
		logic [15:0] w;
		logic [15:0] h;
		logic [15:0] thr;
		logic [15:0] max_r;
		int          sent;
		int          n;
		for (int phase = 0; phase < 10; phase++) begin
			case ($urandom_range(0, 9))
				0: side_d = 16'd0;
				1: side_d = 16'd64;
				2: side_d = 16'($urandom_range(65, 65535));
				default: side_d = 16'($urandom_range(1, 6));
			endcase
			case ($urandom_range(0, 5))
				0: w = 16'($urandom_range(0, 65535));
				1: w = 16'd1;
				default: w = 16'($urandom_range(8, 700));
			endcase
			case ($urandom_range(0, 5))
				0: h = 16'($urandom_range(0, 65535));
				1: h = 16'd1;
				default: h = 16'($urandom_range(8, 700));
			endcase
			case ($urandom_range(0, 5))
				0: thr = 16'd0;
				1: thr = 16'hFFFF;
				default: thr = 16'($urandom_range(0, 40000));
			endcase
			case ($urandom_range(0, 5))
				0: max_r = 16'd0;
				1: max_r = 16'hFFFF;
				default: max_r = 16'($urandom_range(0, 65535));
			endcase
			set_registers(w, h, side_d, thr, 16'($urandom_range(0, 65535)), max_r);
			// every third phase runs without idling
			sender_max_gap = (phase % 3 == 2) ? 0 : 10;
			receiver_max_stall = (phase % 3 == 2) ? 0 : 10;
			sent = 0;
			while (sent < 95) begin
				send_random_patch(n);
				sent += n;
			end
		end
		sender_max_gap = 10;
		receiver_max_stall = 10;
	endtask

	initial begin : stimulus
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_IMAGE_WIDTH;
		cfg_data <= '0;
		in_valid <= 1'b0;
		obstacle_value <= '0;
		pixel_distance <= '0;
		center_x <= '0;
		center_y <= '0;
		last_pixel <= 1'b0;
		reset_labeler_model();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_range_check();
		test_side_extremes();
		test_large_sum();
		test_backpressure();
		test_random_traffic();

		drain_labels();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && expected_labels.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
